/* hw/rtl/assert_macros.svh */
// assertion macros used by the top level of the sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is low
`define I2CM_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("i2cm assertion failed");

// clocked assertion that also holds during reset
`define I2CM_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("i2cm assertion failed");

`endif

/* hw/rtl/i2cm_pkg.sv */
// types and constants of the i2c master bit sequencer
package i2cm_pkg;

  // command codes
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_WACK  = 3'd4;
  localparam logic [2:0] CMD_READ  = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_HALF    = 2'd0;
  localparam logic [1:0] REG_ACKBIT  = 2'd1;
  localparam logic [1:0] REG_SETUP   = 2'd2;
  localparam logic [1:0] REG_TIMEOUT = 2'd3;

  // sequencer phases
  localparam logic [4:0] PH_IDLE = 5'd0;
  localparam logic [4:0] PH_ST_A = 5'd1;
  localparam logic [4:0] PH_ST_B = 5'd2;
  localparam logic [4:0] PH_SP_A = 5'd3;
  localparam logic [4:0] PH_SP_B = 5'd4;
  localparam logic [4:0] PH_TO_A = 5'd5;
  localparam logic [4:0] PH_TO_B = 5'd6;
  localparam logic [4:0] PH_WR_A = 5'd7;
  localparam logic [4:0] PH_WR_B = 5'd8;
  localparam logic [4:0] PH_WR_C = 5'd9;
  localparam logic [4:0] PH_WA_A = 5'd10;
  localparam logic [4:0] PH_WA_B = 5'd11;
  localparam logic [4:0] PH_WA_P = 5'd12;
  localparam logic [4:0] PH_RD_A = 5'd13;
  localparam logic [4:0] PH_RD_B = 5'd14;
  localparam logic [4:0] PH_AK_A = 5'd15;
  localparam logic [4:0] PH_AK_B = 5'd16;

  localparam logic [7:0] MSB_MASK      = 8'h80;
  localparam logic [7:0] TIMEOUT_RESET = 8'd250;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  localparam logic [15:0] HALF_RESET   = 16'd5;
  localparam logic [15:0] ACKBIT_RESET = 16'd2;
  localparam logic [15:0] SETUP_RESET  = 16'd1;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] write_byte;
    logic       send_ack;
    logic       sda_sample;
  } in_item_t;

  typedef struct packed {
    logic       scl_line;
    logic       sda_line;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       no_ack;
  } out_item_t;

  typedef struct packed {
    logic [15:0] half_period_ticks;
    logic [15:0] ack_bit_ticks;
    logic [15:0] ack_setup_ticks;
    logic [7:0]  ack_timeout_limit;
  } cfg_t;

  // sequencer state apart from the delay counter
  typedef struct packed {
    logic [4:0] phase;
    logic [3:0] bit_count;
    logic [7:0] shift_reg;
    logic [7:0] poll_count;
    logic       scl;
    logic       sda;
    logic       no_ack;
    logic       ack_latch;
    logic [7:0] rx_byte;
  } seq_state_t;

endpackage

/* hw/rtl/i2cm_step.sv */
// next-state and result logic for one tick of the sequencer
module i2cm_step #(
  parameter int DELAY_BITS = 16
) (
  input  i2cm_pkg::seq_state_t  st_i,
  input  logic [DELAY_BITS-1:0] delay_i,
  input  i2cm_pkg::cfg_t        cfg_i,
  input  i2cm_pkg::in_item_t    item_i,
  output i2cm_pkg::seq_state_t  st_o,
  output logic [DELAY_BITS-1:0] delay_o,
  output i2cm_pkg::out_item_t   res_o
);
  import i2cm_pkg::*;

  localparam logic [32:0] DelayLim = (33'd1 << DELAY_BITS) - 33'd1;

  // ticks to count-down value: zero acts as one, saturate at the counter
  function automatic logic [DELAY_BITS-1:0] load_delay(input logic [15:0] ticks);
    logic [32:0] t;
    t = {17'd0, ticks};
    if (t == 33'd0) t = 33'd1;
    t = t - 33'd1;
    if (t > DelayLim) t = DelayLim;
    return t[DELAY_BITS-1:0];
  endfunction

  seq_state_t            nx;
  logic [DELAY_BITS-1:0] dl;
  logic                  done;
  logic [7:0]            shifted;
  logic [3:0]            bc_inc;
  logic [15:0]           h;

  assign h       = cfg_i.half_period_ticks;
  assign bc_inc  = st_i.bit_count + 4'd1;
  assign shifted = st_i.shift_reg << 1;

  always_comb begin
    nx   = st_i;
    dl   = delay_i;
    done = 1'b0;
    if (st_i.phase == PH_IDLE) begin
      case (item_i.cmd)
        CMD_START: begin
          nx.phase = PH_ST_A; nx.scl = 1'b1; nx.sda = 1'b1; dl = load_delay(h);
        end
        CMD_STOP: begin
          nx.phase = PH_SP_A; nx.scl = 1'b0; nx.sda = 1'b0; dl = load_delay(h);
        end
        CMD_WRITE: begin
          nx.shift_reg = item_i.write_byte;
          nx.bit_count = '0;
          nx.phase     = PH_WR_A;
          nx.scl       = 1'b0;
          nx.sda       = |(item_i.write_byte & MSB_MASK);
          dl           = load_delay(h);
        end
        CMD_WACK: begin
          nx.poll_count = '0;
          nx.phase      = PH_WA_A;
          nx.sda        = 1'b1;
          dl            = load_delay(cfg_i.ack_setup_ticks);
        end
        CMD_READ: begin
          nx.shift_reg = '0;
          nx.bit_count = '0;
          nx.ack_latch = item_i.send_ack;
          nx.phase     = PH_RD_A;
          nx.scl       = 1'b0;
          nx.sda       = 1'b1;
          dl           = load_delay(h);
        end
        default: ;
      endcase
    end else if (st_i.phase == PH_WA_P) begin
      if (!item_i.sda_sample) begin
        nx.scl    = 1'b0;
        nx.no_ack = 1'b0;
        nx.phase  = PH_IDLE;
        done      = 1'b1;
      end else if (st_i.poll_count >= cfg_i.ack_timeout_limit) begin
        nx.phase = PH_TO_A; nx.scl = 1'b0; nx.sda = 1'b0; dl = load_delay(h);
      end else begin
        nx.poll_count = st_i.poll_count + 8'd1;
      end
    end else if (delay_i != '0) begin
      dl = delay_i - DELAY_BITS'(1);
    end else begin
      case (st_i.phase)
        PH_ST_A: begin
          nx.phase = PH_ST_B; nx.scl = 1'b1; nx.sda = 1'b0; dl = load_delay(h);
        end
        PH_ST_B: begin
          nx.scl = 1'b0; nx.sda = 1'b0; nx.phase = PH_IDLE; done = 1'b1;
        end
        PH_SP_A: begin
          nx.phase = PH_SP_B; nx.scl = 1'b1; nx.sda = 1'b1; dl = load_delay(h);
        end
        PH_SP_B: begin
          nx.phase = PH_IDLE; done = 1'b1;
        end
        PH_TO_A: begin
          nx.phase = PH_TO_B; nx.scl = 1'b1; nx.sda = 1'b1; dl = load_delay(h);
        end
        PH_TO_B: begin
          nx.no_ack = 1'b1; nx.phase = PH_IDLE; done = 1'b1;
        end
        PH_WR_A: begin
          nx.phase = PH_WR_B; nx.scl = 1'b1; dl = load_delay(h);
        end
        PH_WR_B: begin
          nx.phase = PH_WR_C; nx.scl = 1'b0; dl = load_delay(h);
        end
        PH_WR_C: begin
          nx.shift_reg = shifted;
          nx.bit_count = bc_inc;
          if (bc_inc >= BITS_PER_BYTE) begin
            nx.phase = PH_IDLE;
            done     = 1'b1;
          end else begin
            nx.phase = PH_WR_A;
            nx.scl   = 1'b0;
            nx.sda   = |(shifted & MSB_MASK);
            dl       = load_delay(h);
          end
        end
        PH_WA_A: begin
          nx.phase = PH_WA_B; nx.scl = 1'b1; nx.sda = 1'b1;
          dl = load_delay(cfg_i.ack_setup_ticks);
        end
        PH_WA_B: nx.phase = PH_WA_P;
        PH_RD_A: begin
          nx.phase = PH_RD_B; nx.scl = 1'b1; nx.sda = 1'b1; dl = load_delay(h);
        end
        PH_RD_B: begin
          nx.shift_reg = {st_i.shift_reg[6:0], item_i.sda_sample};
          nx.bit_count = bc_inc;
          nx.scl       = 1'b0;
          if (bc_inc >= BITS_PER_BYTE) begin
            // ack low, nack released
            nx.phase = PH_AK_A;
            nx.sda   = ~st_i.ack_latch;
            dl       = load_delay(cfg_i.ack_bit_ticks);
          end else begin
            nx.phase = PH_RD_A;
            nx.sda   = 1'b1;
            dl       = load_delay(h);
          end
        end
        PH_AK_A: begin
          nx.phase = PH_AK_B; nx.scl = 1'b1;
          dl = load_delay(cfg_i.ack_bit_ticks);
        end
        PH_AK_B: begin
          nx.scl     = 1'b0;
          nx.rx_byte = st_i.shift_reg;
          nx.phase   = PH_IDLE;
          done       = 1'b1;
        end
        default: nx.phase = PH_IDLE;
      endcase
    end
  end

  assign st_o    = nx;
  assign delay_o = dl;

  always_comb begin
    res_o.scl_line  = nx.scl;
    res_o.sda_line  = nx.sda;
    res_o.busy_res  = (nx.phase != PH_IDLE);
    res_o.done_res  = done;
    res_o.read_byte = nx.rx_byte;
    res_o.no_ack    = nx.no_ack;
  end

endmodule

/* hw/rtl/i2cm_out_buf.sv */
// two-entry output register with skid slot
module i2cm_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  i2cm_pkg::out_item_t data_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output i2cm_pkg::out_item_t out_item_o
);
  import i2cm_pkg::*;

  out_item_t main_q, skid_q;
  logic      main_v_q, skid_v_q;
  logic      pop;

  assign pop = main_v_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) begin
        main_v_q <= 1'b1;
        skid_v_q <= 1'b0;
      end
    end else if (push_i) begin
      if (!main_v_q || pop) begin
        main_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (pop) begin
      main_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) main_q <= skid_q;
    end else if (push_i) begin
      if (!main_v_q || pop) begin
        main_q <= data_i;
      end else begin
        skid_q <= data_i;
      end
    end
  end

  assign full_o      = skid_v_q;
  assign out_valid_o = main_v_q;
  assign out_item_o  = main_q;

endmodule

/* hw/rtl/i2c_master_bit_sequencer.sv */
// top level of the i2c master bit sequencer
// One input word is one tick of bus timing. A word is taken every clock cycle
// while not stalled, and its result word is registered for output; the sequencer
// state and the result register are the only stages, and a two-word output
// buffer lets the input keep flowing while one result waits. The input stalls
// only when two result words are held. Configuration writes (index 0 half
// period, 1 ack bit phase, 2 ack setup phase, 3 ack timeout) take effect on
// the next word. Phase counters are DELAY_BITS wide; longer phases saturate.
`include "assert_macros.svh"

module i2c_master_bit_sequencer #(
  parameter int DELAY_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  i2cm_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output i2cm_pkg::out_item_t out_item_o
);
  import i2cm_pkg::*;

  cfg_t                  cfg_q;
  seq_state_t            st_q, st_d;
  logic [DELAY_BITS-1:0] delay_q, delay_d;
  out_item_t             res;
  logic                  accept;
  logic                  buf_full;

  assign accept     = in_valid_i & ~buf_full;
  assign in_stall_o = buf_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period_ticks <= HALF_RESET;
      cfg_q.ack_bit_ticks     <= ACKBIT_RESET;
      cfg_q.ack_setup_ticks   <= SETUP_RESET;
      cfg_q.ack_timeout_limit <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HALF:    cfg_q.half_period_ticks <= cfg_wdata_i;
        REG_ACKBIT:  cfg_q.ack_bit_ticks     <= cfg_wdata_i;
        REG_SETUP:   cfg_q.ack_setup_ticks   <= cfg_wdata_i;
        REG_TIMEOUT: cfg_q.ack_timeout_limit <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  i2cm_step #(
    .DELAY_BITS(DELAY_BITS)
  ) u_step (
    .st_i   (st_q),
    .delay_i(delay_q),
    .cfg_i  (cfg_q),
    .item_i (in_item_i),
    .st_o   (st_d),
    .delay_o(delay_d),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase      <= PH_IDLE;
      st_q.bit_count  <= '0;
      st_q.shift_reg  <= '0;
      st_q.poll_count <= '0;
      st_q.scl        <= 1'b1;
      st_q.sda        <= 1'b1;
      st_q.no_ack     <= 1'b0;
      st_q.ack_latch  <= 1'b0;
      st_q.rx_byte    <= '0;
      delay_q         <= '0;
    end else if (accept) begin
      st_q    <= st_d;
      delay_q <= delay_d;
    end
  end

  i2cm_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .data_i     (res),
    .full_o     (buf_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // a completed command never reports busy
  `I2CM_ASSERT(a_done_not_busy, clk_i, rst_ni,
    out_valid_o |-> !(out_item_o.done_res && out_item_o.busy_res))
  // input stalls only while a result is held
  `I2CM_ASSERT(a_stall_has_out, clk_i, rst_ni, in_stall_o |-> out_valid_o)
  // a low poll ends the acknowledge wait
  `I2CM_ASSERT(a_ack_ends, clk_i, rst_ni,
    (accept && st_q.phase == PH_WA_P && !in_item_i.sda_sample) |=> st_q.phase == PH_IDLE)
  // while counting down the phase holds
  `I2CM_ASSERT(a_count_holds, clk_i, rst_ni,
    (accept && st_q.phase != PH_IDLE && st_q.phase != PH_WA_P && delay_q != '0)
      |=> st_q.phase == $past(st_q.phase))

endmodule
